/* design/tadc_pkg.sv */
// Package for the thermistor ADC to temperature converter.
// Holds the operation codes, field widths and the segment temperature tables.
// Depends on nothing; used by thermistor_adc_to_temperature_core.
`default_nettype none

package tadc_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int INDEX_BITS = $clog2(TABLE_ENTRIES);
	localparam int ENTRY_BITS = 16;
	localparam int TEMP_BITS = 8;
	localparam int READING_BITS_DEF = 16;
	localparam int QUOT_BITS = 4;

	localparam logic signed [TEMP_BITS-1:0] TEMP_HOT = 8'sd80;
	localparam logic signed [TEMP_BITS-1:0] TEMP_COLD = -8'sd25;

	// ceil(2^22 / 5); exact floor division by five for values below 2^22.
	localparam logic [19:0] RECIP_FIVE = 20'd838861;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_RAW    = 2'd1,
		OP_SCALED = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	function automatic logic signed [TEMP_BITS-1:0] seg_temp(input logic [INDEX_BITS-1:0] i);
		logic signed [TEMP_BITS-1:0] t;
		case (i)
			4'd0: t = -8'sd25;
			4'd1: t = -8'sd15;
			4'd2: t = -8'sd10;
			4'd3: t = -8'sd5;
			4'd4: t = 8'sd0;
			4'd5: t = 8'sd5;
			4'd6: t = 8'sd10;
			4'd7: t = 8'sd20;
			4'd8: t = 8'sd30;
			4'd9: t = 8'sd40;
			4'd10: t = 8'sd45;
			4'd11: t = 8'sd50;
			4'd12: t = 8'sd55;
			4'd13: t = 8'sd60;
			4'd14: t = 8'sd70;
			default: t = 8'sd80;
		endcase
		return t;
	endfunction

	// Temperature step from segment i to segment i + 1.
	function automatic logic [QUOT_BITS-1:0] seg_span(input logic [INDEX_BITS-1:0] i);
		logic [QUOT_BITS-1:0] s;
		case (i)
			4'd0, 4'd6, 4'd7, 4'd8, 4'd13, 4'd14: s = 4'd10;
			4'd15: s = 4'd0;
			default: s = 4'd5;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

/* design/thermistor_adc_to_temperature_core.sv */
// Top level of the thermistor ADC to temperature converter: an eight stage pipeline.
// Holds the breakpoint table, the scaling multiplier and a pipelined divider.
// Depends on tadc_pkg.
//
//   channel   direction   tdata                              tuser
//   s_*       in          index, breakpoint value, reading   operation
//   m_*       out         temperature                        bad segment flag
//
// One item enters per cycle while the pipeline is not held; a convert item's result leaves from stage eight.
// Load items and unused operations give no result and leave a bubble behind them.
// A load writes the table when it reaches stage four, so every later item sees it.
// Reset clears the valid bits only; the table is undefined until loaded.
// The whole pipeline holds while a result waits on m_tready.
`default_nettype none

module thermistor_adc_to_temperature_core #(
	parameter int READING_BITS = tadc_pkg::READING_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output      logic                          s_tready,
	// entry_index [3:0], entry_value [19:4], reading [35:20], zero [39:36]
	input  wire logic [39:0]                   s_tdata,
	// operation [1:0]
	input  wire tadc_pkg::op_t                 s_tuser,
	output      logic                          m_tvalid,
	input  wire logic                          m_tready,
	// temperature [7:0]
	output      logic [tadc_pkg::TEMP_BITS-1:0] m_tdata,
	// bad_segment [0]
	output      logic                          m_tuser
);
	import tadc_pkg::*;

	localparam int RB = READING_BITS;
	localparam int AW = RB - 3;
	localparam int PW = AW + 20;
	localparam int EB = ENTRY_BITS;
	localparam int RW = EB + QUOT_BITS;

	logic en;

	logic [EB-1:0] bp_q [TABLE_ENTRIES];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	op_t op_s1, op_s2, op_s3, op_s4;
	logic [INDEX_BITS-1:0] idx_s1, idx_s2, idx_s3, idx_s4;
	logic [EB-1:0] val_s1, val_s2, val_s3, val_s4;
	logic [RB-1:0] rd_s1, rd_s2, rd_s3, rd_s4;
	logic [AW-1:0] a_s2;
	logic [PW-1:0] prod_s3;

	logic hot_s5, hot_s6, hot_s7;
	logic none_s5, none_s6, none_s7;
	logic [INDEX_BITS-1:0] seg_s5, seg_s6, seg_s7;
	logic [EB-1:0] num_s5;
	logic signed [EB:0] den_s5;
	logic [EB-1:0] den_s6, den_s7;
	logic bad_s6, bad_s7;
	logic [RW-1:0] mul_s6, rem_s7;
	logic [1:0] qh_s7;
	logic [TEMP_BITS-1:0] temp_s8;
	logic bad_s8;

	logic [RB+3:0] rx10;
	logic [EB-1:0] rd16;
	logic [TABLE_ENTRIES-1:0] lt;
	logic [TABLE_ENTRIES-2:0] pick;
	logic [EB-1:0] num_c;
	logic [EB:0] den_c;
	logic [INDEX_BITS-1:0] seg_c;
	logic none_c;
	logic [RW-1:0] rem_c7;
	logic [1:0] qh_c7;
	logic [TEMP_BITS-1:0] temp_c8;

	assign en = !v_s8 || m_tready;
	assign s_tready = en;
	assign m_tvalid = v_s8;
	assign m_tdata = temp_s8;
	assign m_tuser = bad_s8;

	assign rx10 = {1'b0, rd_s1, 3'b000} + {3'b000, rd_s1, 1'b0};
	assign rd16 = EB'(rd_s4);

	always_comb begin
		logic above;
		num_c = '0;
		den_c = '0;
		seg_c = '0;
		for (int j = 0; j < TABLE_ENTRIES; j++) begin
			lt[j] = rd16 < bp_q[j];
		end
		for (int j = 0; j < TABLE_ENTRIES - 1; j++) begin
			above = 1'b0;
			for (int k = j + 1; k < TABLE_ENTRIES - 1; k++) begin
				above = above | lt[k];
			end
			pick[j] = lt[j] & ~above;
		end
		for (int j = 0; j < TABLE_ENTRIES - 1; j++) begin
			if (pick[j]) begin
				num_c = num_c | (bp_q[j] - rd16);
				den_c = den_c | ({1'b0, bp_q[j]} - {1'b0, bp_q[j+1]});
				seg_c = seg_c | INDEX_BITS'(j);
			end
		end
		none_c = ~|pick;
	end

	always_comb begin
		logic [RW-1:0] r;
		logic [RW-1:0] d;
		r = mul_s6;
		for (int k = 3; k >= 2; k--) begin
			d = RW'(den_s6) << k;
			qh_c7[k-2] = r >= d;
			if (r >= d) begin
				r = r - d;
			end
		end
		rem_c7 = r;
	end

	always_comb begin
		logic [RW-1:0] r;
		logic [RW-1:0] d;
		logic [1:0] ql;
		r = rem_s7;
		for (int k = 1; k >= 0; k--) begin
			d = RW'(den_s7) << k;
			ql[k] = r >= d;
			if (r >= d) begin
				r = r - d;
			end
		end
		if (hot_s7) begin
			temp_c8 = TEMP_HOT;
		end else if (none_s7) begin
			temp_c8 = TEMP_COLD;
		end else if (bad_s7) begin
			temp_c8 = seg_temp(seg_s7);
		end else begin
			temp_c8 = seg_temp(seg_s7) + TEMP_BITS'({qh_s7, ql});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4 && (op_s4 == OP_RAW || op_s4 == OP_SCALED);
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s4 && op_s4 == OP_LOAD) begin
			bp_q[idx_s4] <= val_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= s_tuser;
			idx_s1 <= s_tdata[INDEX_BITS-1:0];
			val_s1 <= s_tdata[19:4];
			rd_s1 <= s_tdata[20 +: RB];

			op_s2 <= op_s1;
			idx_s2 <= idx_s1;
			val_s2 <= val_s1;
			rd_s2 <= rd_s1;
			a_s2 <= rx10[RB+3:7];

			op_s3 <= op_s2;
			idx_s3 <= idx_s2;
			val_s3 <= val_s2;
			rd_s3 <= rd_s2;
			prod_s3 <= PW'(a_s2) * PW'(RECIP_FIVE);

			op_s4 <= op_s3;
			idx_s4 <= idx_s3;
			val_s4 <= val_s3;
			rd_s4 <= (op_s3 == OP_SCALED) ? prod_s3[16 +: RB] : rd_s3;

			hot_s5 <= lt[TABLE_ENTRIES-1];
			none_s5 <= none_c;
			seg_s5 <= seg_c;
			num_s5 <= num_c;
			den_s5 <= $signed(den_c);

			hot_s6 <= hot_s5;
			none_s6 <= none_s5;
			seg_s6 <= seg_s5;
			mul_s6 <= RW'(num_s5) * RW'(seg_span(seg_s5));
			den_s6 <= den_s5[EB-1:0];
			bad_s6 <= den_s5 <= 0;

			hot_s7 <= hot_s6;
			none_s7 <= none_s6;
			seg_s7 <= seg_s6;
			den_s7 <= den_s6;
			bad_s7 <= bad_s6;
			rem_s7 <= rem_c7;
			qh_s7 <= qh_c7;

			temp_s8 <= temp_c8;
			bad_s8 <= bad_s7 && !hot_s7 && !none_s7;
		end
	end

endmodule

`default_nettype wire
